// File: rtl/core/bfu_pkg.sv
// shared types and constants for the boids flock update block
// no dependencies
`timescale 1ns / 1ps
package bfu_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SELF,
    ST_LAT_SELF,
    ST_RD_OTHER,
    ST_ACC_OTHER,
    ST_TERM,
    ST_TERM_WAIT,
    ST_WRITE,
    ST_EMIT
  } state_t;

  localparam logic [2:0] REG_COUNT  = 3'd0;
  localparam logic [2:0] REG_SEP    = 3'd1;
  localparam logic [2:0] REG_ALIGN  = 3'd2;
  localparam logic [2:0] REG_COH    = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_RECIP  = 3'd5;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    else if (v < S32_MIN) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// File: rtl/core/bfu_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
module bfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/bfu_mul.sv
// shared scaled multiply unit: floor(val * gain >> sh) saturated to 32 bits
// magnitude times gain done as a 32x32 and a 16x32 partial product over cycles; uses bfu_pkg
`timescale 1ns / 1ps
module bfu_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [47:0]  val,
  input  logic [31:0]         gain,
  input  logic [4:0]          sh,
  output logic                done,
  output logic signed [31:0]  res,
  output logic [31:0]         raw
);
  import bfu_pkg::*;

  logic        neg;
  logic [47:0] mag;
  logic [31:0] gn;
  logic [4:0]  shr;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [2:0]  stage;
  logic [80:0] prod;
  logic [80:0] q;
  logic        fracnz;
  logic [80:0] lowmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 3'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (stage)
        3'd0: if (start) begin
          neg   <= val < 0;
          mag   <= val < 0 ? 48'(-val) : 48'(val);
          gn    <= gain;
          shr   <= sh;
          stage <= 3'd1;
        end
        3'd1: begin
          plo   <= 64'(mag[31:0]) * 64'(gn);
          stage <= 3'd2;
        end
        3'd2: begin
          phi   <= 64'(mag[47:32]) * 64'(gn);
          stage <= 3'd3;
        end
        3'd3: begin
          prod  <= 81'(plo) + {phi[48:0], 32'd0};
          stage <= 3'd4;
        end
        3'd4: begin
          if (neg) begin
            if ((q + 81'(fracnz)) > 81'h80000000) res <= 32'sh80000000;
            else res <= 32'(-(q + 81'(fracnz)));
          end else begin
            if (q > 81'h7fffffff) res <= 32'sh7fffffff;
            else res <= q[31:0];
          end
          // unsaturated low word of the shifted product
          raw   <= q[31:0];
          done  <= 1'b1;
          stage <= 3'd0;
        end
        default: stage <= 3'd0;
      endcase
    end
  end

  always_comb begin
    lowmask = (81'd1 << shr) - 81'd1;
    q       = prod >> shr;
    fracnz  = |(prod & lowmask);
  end
endmodule

// File: rtl/core/boids_flock_update_step.sv
// top level of the boids flock update block: sequencer, flock store and datapath
// uses bfu_pkg, bfu_ram, bfu_mul
`timescale 1ns / 1ps
// usage:
// items enter on in_valid/in_ready. a load transaction (action 0) writes one
// boid into the flock store and gives no result. a tick transaction (action 1)
// updates boids 0..n-1 in place and emits one result per boid on
// out_valid/out_ready, last_boid marking boid n-1. per boid: one read of
// itself, then n reads of the flock, then nine scaled multiplies on the
// shared multiply unit, one write, one emit. in_ready is low for the whole
// tick. a stalled receiver holds the block in its emit state; nothing is lost.
// reset clears control state and loads the register defaults; the store holds
// no defined contents until loaded. configuration is taken through cfg_we,
// cfg_index and cfg_data at any edge and should only change while idle.
module boids_flock_update_step #(
  parameter int MAX_BOIDS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [4:0]         boid_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               last_boid
);
  import bfu_pkg::*;

  localparam int AW = $clog2(MAX_BOIDS);
  localparam int CW = AW + 1;

  logic [5:0]  flock_count;
  logic [31:0] separation_gain, alignment_gain, cohesion_gain, separation_radius;
  logic [15:0] others_reciprocal;

  state_t state, state_next;

  logic [CW-1:0] n, i, j;
  logic [3:0]    term;
  logic signed [31:0] xi, yi, vxi, vyi;
  logic signed [47:0] sep_x, sep_y, dvx, dvy, ox, oy;
  logic signed [31:0] mx, my;
  logic signed [63:0] vx_acc, vy_acc;
  logic [31:0] align_coef;
  logic signed [31:0] px_r, py_r, vx_r, vy_r;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [127:0]  wdata, rdata;

  bfu_ram #(.WIDTH(128), .DEPTH(MAX_BOIDS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic signed [31:0] rpx, rpy, rvx, rvy;
  assign rpx = rdata[127:96];
  assign rpy = rdata[95:64];
  assign rvx = rdata[63:32];
  assign rvy = rdata[31:0];

  // shared multiplier
  logic               m_start, m_done;
  logic signed [47:0] m_val;
  logic [31:0]        m_gain;
  logic [4:0]         m_sh;
  logic signed [31:0] m_res;
  logic [31:0]        m_raw;

  bfu_mul u_mul (
    .clk(clk), .rst(rst), .start(m_start), .val(m_val), .gain(m_gain),
    .sh(m_sh), .done(m_done), .res(m_res), .raw(m_raw)
  );

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      flock_count       <= 6'd2;
      separation_gain   <= '0;
      alignment_gain    <= '0;
      cohesion_gain     <= '0;
      separation_radius <= '0;
      others_reciprocal <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:  flock_count       <= cfg_data[5:0];
        REG_SEP:    separation_gain   <= cfg_data;
        REG_ALIGN:  alignment_gain    <= cfg_data;
        REG_COH:    cohesion_gain     <= cfg_data;
        REG_RADIUS: separation_radius <= cfg_data;
        REG_RECIP:  others_reciprocal <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // neighbor test on the registered read data
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  logic [65:0] r2, ax2, ay2;
  logic        close;
  always_comb begin
    dx    = 33'(rpx) - 33'(xi);
    dy    = 33'(rpy) - 33'(yi);
    ax    = dx < 0 ? 33'(-dx) : 33'(dx);
    ay    = dy < 0 ? 33'(-dy) : 33'(dy);
    r2    = 66'(separation_radius) * 66'(separation_radius);
    ax2   = 66'(ax[31:0]) * 66'(ax[31:0]);
    ay2   = 66'(ay[31:0]) * 66'(ay[31:0]);
    close = (dx != 0 || dy != 0) && ax < 33'(separation_radius) &&
            ay < 33'(separation_radius) && ay2 < (r2 - ax2);
  end

  // multiply operand select per term
  always_comb begin
    m_val  = '0;
    m_gain = '0;
    m_sh   = 5'(FRAC_BITS);
    case (term)
      4'd0: begin m_val = 48'(alignment_gain); m_gain = 32'(others_reciprocal); m_sh = 5'd16; end
      4'd1: begin m_val = ox; m_gain = 32'(others_reciprocal); m_sh = 5'd16; end
      4'd2: begin m_val = oy; m_gain = 32'(others_reciprocal); m_sh = 5'd16; end
      4'd3: begin m_val = sep_x; m_gain = separation_gain; end
      4'd4: begin m_val = sep_y; m_gain = separation_gain; end
      4'd5: begin m_val = dvx; m_gain = align_coef; end
      4'd6: begin m_val = dvy; m_gain = align_coef; end
      4'd7: begin m_val = 48'(mx) - 48'(xi); m_gain = cohesion_gain; end
      4'd8: begin m_val = 48'(my) - 48'(yi); m_gain = cohesion_gain; end
      default: ;
    endcase
  end

  // fsm next state and outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    we         = 1'b0;
    waddr      = boid_index[AW-1:0];
    wdata      = {in_pos_x, in_pos_y, in_vel_x, in_vel_y};
    raddr      = j[AW-1:0];
    m_start    = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_LOAD) begin
            we = 32'(boid_index) < MAX_BOIDS;
          end else if (n != 0) begin
            state_next = ST_RD_SELF;
          end
        end
      end
      ST_RD_SELF:   begin raddr = i[AW-1:0]; state_next = ST_LAT_SELF; end
      ST_LAT_SELF:  state_next = ST_RD_OTHER;
      ST_RD_OTHER:  state_next = ST_ACC_OTHER;
      ST_ACC_OTHER: state_next = (j == n - 1'b1) ? ST_TERM : ST_RD_OTHER;
      ST_TERM:      begin m_start = 1'b1; state_next = ST_TERM_WAIT; end
      ST_TERM_WAIT: if (m_done) state_next = (term == 4'd8) ? ST_WRITE : ST_TERM;
      ST_WRITE: begin
        we         = 1'b1;
        waddr      = i[AW-1:0];
        wdata      = {px_r, py_r, vx_r, vy_r};
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = (i == n - 1'b1) ? ST_IDLE : ST_RD_SELF;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    n = (32'(flock_count) > MAX_BOIDS) ? CW'(MAX_BOIDS) : CW'(flock_count);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      i    <= '0;
      j    <= '0;
      term <= '0;
    end else begin
      case (state)
        ST_IDLE: begin i <= '0; j <= '0; end
        ST_LAT_SELF: begin
          xi <= rpx; yi <= rpy; vxi <= rvx; vyi <= rvy;
          sep_x <= '0; sep_y <= '0; dvx <= '0; dvy <= '0; ox <= '0; oy <= '0;
          j <= '0;
        end
        ST_ACC_OTHER: begin
          dvx <= dvx + 48'(rvx) - 48'(vxi);
          dvy <= dvy + 48'(rvy) - 48'(vyi);
          if (j != i) begin
            ox <= ox + 48'(rpx);
            oy <= oy + 48'(rpy);
          end
          if (close) begin
            sep_x <= sep_x - 48'(dx);
            sep_y <= sep_y - 48'(dy);
          end
          j    <= j + 1'b1;
          term <= '0;
        end
        ST_TERM: if (term == 4'd3) begin
          vx_acc <= 64'(vxi);
          vy_acc <= 64'(vyi);
        end
        ST_TERM_WAIT: if (m_done) begin
          case (term)
            // gain times reciprocal can exceed the signed range, take it unsaturated
            4'd0: align_coef <= m_raw;
            4'd1: mx <= m_res;
            4'd2: my <= m_res;
            4'd3, 4'd5, 4'd7: vx_acc <= vx_acc + 64'(m_res);
            4'd4, 4'd6, 4'd8: vy_acc <= vy_acc + 64'(m_res);
            default: ;
          endcase
          term <= term + 1'b1;
        end
        ST_WRITE: ;
        ST_EMIT: if (out_ready) i <= i + 1'b1;
        default: ;
      endcase
    end
  end

  // x terms are complete before the last multiply; y takes the last one directly
  logic signed [31:0] vxs, vys;
  always_comb begin
    vxs = sat32(vx_acc);
    vys = sat32(vy_acc + 64'(m_res));
  end

  always_ff @(posedge clk) begin
    if (state == ST_TERM_WAIT && term == 4'd8 && m_done) begin
      vx_r <= vxs;
      vy_r <= vys;
      px_r <= sat32(64'(xi) + 64'(vxs));
      py_r <= sat32(64'(yi) + 64'(vys));
    end
  end

  assign out_index = 5'(i);
  assign out_pos_x = px_r;
  assign out_pos_y = py_r;
  assign out_vel_x = vx_r;
  assign out_vel_y = vy_r;
  assign last_boid = (i == n - 1'b1);
endmodule

// File: dv/boids_flock_update_step_tb.sv
// self-checking testbench for the boids flock update block
// depends on bfu_pkg and boids_flock_update_step; a built-in flock model predicts each tick
`timescale 1ns / 1ps
module boids_flock_update_step_tb;
  import bfu_pkg::*;

  localparam int FLOCK_MAX = 32;
  localparam int FRACW = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] px, py, vx, vy;
    logic               last;
  } boid_rec_t;

  typedef struct {
    logic               act;
    logic [4:0]         idx;
    logic signed [31:0] px, py, vx, vy;
    bit                 typed;
    boid_rec_t          e0, e1;
  } stim_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic action = ACT_LOAD;
  logic [4:0] boid_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic out_valid, out_ready = 0;
  logic [4:0] out_index;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic last_boid;

  boids_flock_update_step dut (.*);

  always #5 clk = ~clk;

  // flock model state and configuration
  longint    pos_x_m[FLOCK_MAX], pos_y_m[FLOCK_MAX], vel_x_m[FLOCK_MAX], vel_y_m[FLOCK_MAX];
  bit [5:0]  count_m;
  bit [31:0] sep_gain_m, align_gain_m, coh_gain_m, radius_m;
  bit [15:0] recip_m;
  bit        loaded[FLOCK_MAX];

  boid_rec_t pending_boids[$];
  int  errors = 0;
  bit  quiet = 0;
  int  stall_cycles = 0;

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(val * gain / 2^sh), saturated to 32 bits
  function automatic longint scale_floor(input longint val, input bit [63:0] gain,
                                         input int sh);
    bit        neg;
    bit [63:0] mag, p, q;
    neg = val < 0;
    mag = neg ? -val : val;
    if (mag == 0 || gain == 0) return 0;
    if (mag > 64'hffff_ffff_ffff_ffff / gain) return neg ? -64'sd2147483648 : 64'sd2147483647;
    p = mag * gain;
    q = p >> sh;
    if (neg) begin
      if ((p & ((64'd1 << sh) - 1)) != 0) q++;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return longint'(q);
  endfunction

  function automatic bit [63:0] mag_of(input longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic flock_tick(ref boid_rec_t res[$]);
    int n;
    bit [63:0] r2, acoef, ax, ay;
    longint xi, yi, vxi, vyi, sx, sy, dvx, dvy, ox, oy, dx, dy, mx, my, vx, vy;
    boid_rec_t r;
    n = (count_m > FLOCK_MAX) ? FLOCK_MAX : count_m;
    r2 = 64'(radius_m) * 64'(radius_m);
    acoef = (64'(align_gain_m) * 64'(recip_m)) >> 16;
    for (int i = 0; i < n; i++) begin
      xi = pos_x_m[i]; yi = pos_y_m[i]; vxi = vel_x_m[i]; vyi = vel_y_m[i];
      sx = 0; sy = 0; dvx = 0; dvy = 0; ox = 0; oy = 0;
      for (int j = 0; j < n; j++) begin
        dx = pos_x_m[j] - xi;
        dy = pos_y_m[j] - yi;
        ax = mag_of(dx); ay = mag_of(dy);
        dvx += vel_x_m[j] - vxi;
        dvy += vel_y_m[j] - vyi;
        if (j != i) begin
          ox += pos_x_m[j];
          oy += pos_y_m[j];
        end
        if ((dx != 0 || dy != 0) && ax < radius_m && ay < radius_m &&
            ay * ay < r2 - ax * ax) begin
          sx -= dx;
          sy -= dy;
        end
      end
      mx = scale_floor(ox, 64'(recip_m), 16);
      my = scale_floor(oy, 64'(recip_m), 16);
      vx = sat_word(vxi + scale_floor(sx, 64'(sep_gain_m), FRACW)
                    + scale_floor(dvx, acoef, FRACW)
                    + scale_floor(mx - xi, 64'(coh_gain_m), FRACW));
      vy = sat_word(vyi + scale_floor(sy, 64'(sep_gain_m), FRACW)
                    + scale_floor(dvy, acoef, FRACW)
                    + scale_floor(my - yi, 64'(coh_gain_m), FRACW));
      pos_x_m[i] = sat_word(xi + vx);
      pos_y_m[i] = sat_word(yi + vy);
      vel_x_m[i] = vx;
      vel_y_m[i] = vy;
      r.idx = 5'(i); r.px = pos_x_m[i]; r.py = pos_y_m[i]; r.vx = vx; r.vy = vy;
      r.last = (i == n - 1);
      res.insert(res.size(), r);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = data;
    case (idx)
      REG_COUNT:  count_m = data[5:0];
      REG_SEP:    sep_gain_m = data;
      REG_ALIGN:  align_gain_m = data;
      REG_COH:    coh_gain_m = data;
      REG_RADIUS: radius_m = data;
      REG_RECIP:  recip_m = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_item(input stim_t it);
    boid_rec_t res[$];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1; action = it.act; boid_index = it.idx;
    in_pos_x = it.px; in_pos_y = it.py; in_vel_x = it.vx; in_vel_y = it.vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transaction accepted: update the model
    if (it.act == ACT_LOAD) begin
      pos_x_m[it.idx] = it.px; pos_y_m[it.idx] = it.py;
      vel_x_m[it.idx] = it.vx; vel_y_m[it.idx] = it.vy;
      loaded[it.idx] = 1;
    end else begin
      flock_tick(res);
      if (it.typed) begin
        pending_boids.insert(pending_boids.size(), it.e0);
        pending_boids.insert(pending_boids.size(), it.e1);
      end else begin
        foreach (res[k]) pending_boids.insert(pending_boids.size(), res[k]);
      end
    end
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain;
    while (pending_boids.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    if (m < 8) return $urandom;
    if (m == 8) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hffffffff;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 17);
    endcase
  endfunction

  // results channel: stall bursts, then compare against the oldest expected boid
  always @(negedge clk) begin
    if (quiet) out_ready <= 1;
    else if (!out_ready) out_ready <= ($urandom_range(0, 3) == 0) ? 0 : 1;
    else if ($urandom_range(0, 5) == 0) out_ready <= 0;
    else out_ready <= 1;
  end

  always @(posedge clk) begin
    boid_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_boids.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected boid result idx=%0d", out_index);
      end else begin
        e = pending_boids.pop_front();
        if (out_index !== e.idx || out_pos_x !== e.px || out_pos_y !== e.py ||
            out_vel_x !== e.vx || out_vel_y !== e.vy || last_boid !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp idx=%0d p=(%h,%h) v=(%h,%h) last=%b got idx=%0d p=(%h,%h) v=(%h,%h) last=%b",
                     e.idx, e.px, e.py, e.vx, e.vy, e.last, out_index, out_pos_x,
                     out_pos_y, out_vel_x, out_vel_y, last_boid);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  stim_t directed_rows[6];
  bit [5:0] phase_counts[8] = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd3, 6'd33, 6'd4, 6'd2};

  initial begin
    stim_t it;
    int n, nxt;
    // with reset gains zero, a tick only moves each boid by its own velocity
    directed_rows[0] = '{ACT_LOAD, 5'd0, 1, 2, 3, 4, 0, '{default:0}, '{default:0}};
    directed_rows[1] = '{ACT_LOAD, 5'd1, 32'sh7fffffff, 32'sh80000000, 1, -1, 0,
                         '{default:0}, '{default:0}};
    directed_rows[2] = '{ACT_TICK, 5'd0, 0, 0, 0, 0, 1,
                         '{5'd0, 4, 6, 3, 4, 1'b0},
                         '{5'd1, 32'sh7fffffff, 32'sh80000000, 1, -1, 1'b1}};
    directed_rows[3] = '{ACT_LOAD, 5'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                         32'sh7fffffff, 0, '{default:0}, '{default:0}};
    directed_rows[4] = '{ACT_LOAD, 5'd31, 32'shffffffff, 32'shffffffff, 32'shffffffff,
                         32'shffffffff, 0, '{default:0}, '{default:0}};
    directed_rows[5] = '{ACT_TICK, 5'd0, 0, 0, 0, 0, 1,
                         '{5'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0},
                         '{5'd1, 32'sh7fffffff, 32'sh80000000, 1, -1, 1'b1}};
    count_m = 2; sep_gain_m = 0; align_gain_m = 0; coh_gain_m = 0; radius_m = 0;
    recip_m = 16'hffff;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed_rows[r]) send_item(directed_rows[r]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1;
      cfg_write(REG_COUNT, phase_counts[ph]);
      n = (count_m > FLOCK_MAX) ? FLOCK_MAX : count_m;
      if (ph == 2) begin
        cfg_write(REG_SEP, 32'hffffffff); cfg_write(REG_ALIGN, 32'hffffffff);
        cfg_write(REG_COH, 32'hffffffff); cfg_write(REG_RADIUS, 32'hffffffff);
        cfg_write(REG_RECIP, 16'hffff);
      end else if (ph == 3) begin
        cfg_write(REG_SEP, 0); cfg_write(REG_ALIGN, 0);
        cfg_write(REG_COH, 0); cfg_write(REG_RADIUS, 0);
        cfg_write(REG_RECIP, 0);
      end else begin
        cfg_write(REG_SEP, rand_gain()); cfg_write(REG_ALIGN, rand_gain());
        cfg_write(REG_COH, rand_gain());
        cfg_write(REG_RADIUS, $urandom_range(0, 1) ? $urandom_range(0, 3 << 16) : $urandom);
        // mostly the matching reciprocal, sometimes a mismatched one
        if (n > 1 && $urandom_range(0, 3) != 0) cfg_write(REG_RECIP, 65535 / (n - 1));
        else cfg_write(REG_RECIP, $urandom_range(0, 65535));
      end

      for (int k = 0; k < 34; k++) begin
        nxt = -1;
        for (int b = n - 1; b >= 0; b--) if (!loaded[b]) nxt = b;
        it = '{default:0};
        if (nxt < 0 && $urandom_range(0, 9) < 3) begin
          it.act = ACT_TICK;
          // junk payload on a tick must be ignored
          it.idx = $urandom; it.px = $urandom; it.py = $urandom;
          it.vx = $urandom; it.vy = $urandom;
        end else begin
          it.act = ACT_LOAD;
          it.idx = (nxt >= 0) ? nxt : $urandom_range(0, 31);
          it.px = rand_word(); it.py = rand_word();
          it.vx = rand_word(); it.vy = rand_word();
        end
        send_item(it);
        if (it.act == ACT_TICK && $urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
